// File: hdl/pqqs_pkg.sv
// Shared types, widths and codes for the priority queue quantum server.
package pqqs_pkg;

  // Default number of queue entries.
  localparam int unsigned DEPTH_DEFAULT = 16;

  // Field widths.
  localparam int unsigned WORK_W   = 8;
  localparam int unsigned URG_W    = 4;
  localparam int unsigned LETTER_W = 5;
  localparam int unsigned NUMBER_W = 14;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned COUNT_W  = 5;

  // Quantum after reset, ticket wrap points.
  localparam logic [WORK_W-1:0]   QUANTUM_RESET = WORK_W'(3);
  localparam logic [NUMBER_W-1:0] NUMBER_FIRST  = NUMBER_W'(1);
  localparam logic [NUMBER_W-1:0] NUMBER_LAST   = NUMBER_W'(9999);
  localparam logic [LETTER_W-1:0] LETTER_FIRST  = LETTER_W'(0);
  localparam logic [LETTER_W-1:0] LETTER_LAST   = LETTER_W'(25);

  // Request kinds.
  localparam logic KIND_ENQUEUE = 1'b0;
  localparam logic KIND_SERVE   = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED    = STATUS_W'(0);
  localparam logic [STATUS_W-1:0] ST_FULL     = STATUS_W'(1);
  localparam logic [STATUS_W-1:0] ST_EMPTY    = STATUS_W'(2);
  localparam logic [STATUS_W-1:0] ST_DONE     = STATUS_W'(3);
  localparam logic [STATUS_W-1:0] ST_REQUEUED = STATUS_W'(4);

  // One stored queue entry.
  typedef struct packed {
    logic [WORK_W-1:0]   work;
    logic [URG_W-1:0]    urg;
    logic [LETTER_W-1:0] letter;
    logic [NUMBER_W-1:0] number;
  } entry_t;

  // One result.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [URG_W-1:0]    urg;
    logic [LETTER_W-1:0] letter;
    logic [NUMBER_W-1:0] number;
    logic [WORK_W-1:0]   work;
    logic [COUNT_W-1:0]  count;
  } result_t;

  // Shared compare / subtract unit outputs.
  typedef struct packed {
    logic              gt;
    logic [WORK_W-1:0] diff;
  } alu_res_t;

endpackage

// File: hdl/pqqs_store.sv
// Entry memory: one write port, one read port with registered read data.
module pqqs_store #(
  parameter int unsigned QUEUE_DEPTH = pqqs_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW          = $clog2(QUEUE_DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  pqqs_pkg::entry_t  wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output pqqs_pkg::entry_t  rd_data
);

  pqqs_pkg::entry_t mem [QUEUE_DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hdl/pqqs_alu.sv
// Shared compare and subtract unit used by the scan and serve steps.
module pqqs_alu (
  input  logic [pqqs_pkg::WORK_W-1:0] a,
  input  logic [pqqs_pkg::WORK_W-1:0] b,
  output pqqs_pkg::alu_res_t          res
);

  // a > b, and a - b for the requeue work
  always_comb begin
    res.gt   = (a > b);
    res.diff = a - b;
  end

endmodule

// File: hdl/pqqs_seq.sv
// Sequencer: request capture, insert scan and shift, serve, result register.
module pqqs_seq #(
  parameter int unsigned QUEUE_DEPTH = pqqs_pkg::DEPTH_DEFAULT,
  parameter int unsigned AW          = $clog2(QUEUE_DEPTH),
  parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  // configuration
  input  logic                                cfg_write,
  input  logic [pqqs_pkg::WORK_W-1:0]         cfg_data,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                kind,
  input  logic [pqqs_pkg::WORK_W-1:0]         work_units,
  input  logic [pqqs_pkg::URG_W-1:0]          urgency,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output pqqs_pkg::result_t                   out_res,
  // memory
  output logic                                mem_wr_en,
  output logic                                mem_rd_en,
  output logic [AW-1:0]                       mem_addr,
  output pqqs_pkg::entry_t                    mem_wr_data,
  input  pqqs_pkg::entry_t                    mem_rd_data,
  // shared unit
  output logic [pqqs_pkg::WORK_W-1:0]         alu_a,
  output logic [pqqs_pkg::WORK_W-1:0]         alu_b,
  input  pqqs_pkg::alu_res_t                  alu_res
);

  localparam int unsigned SW = CW + 1;
  localparam logic [SW-1:0] DEPTH_S   = SW'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DEPTH_C   = CW'(QUEUE_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_SCAN_RD   = 9'b000000010,
    S_SCAN_CHK  = 9'b000000100,
    S_SHIFT_RD  = 9'b000001000,
    S_SHIFT_WR  = 9'b000010000,
    S_WRITE     = 9'b000100000,
    S_SERVE_RD  = 9'b001000000,
    S_SERVE_CHK = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t                          state;
  logic [AW-1:0]                   head;
  logic [CW-1:0]                   occ;
  logic [CW-1:0]                   idx;
  logic [CW-1:0]                   pos;
  logic [pqqs_pkg::WORK_W-1:0]     quantum;
  logic [pqqs_pkg::WORK_W-1:0]     req_work;
  logic [pqqs_pkg::URG_W-1:0]      req_urg;
  logic [pqqs_pkg::LETTER_W-1:0]   tk_letter;
  logic [pqqs_pkg::NUMBER_W-1:0]   tk_number;
  logic [pqqs_pkg::LETTER_W-1:0]   next_letter;
  logic [pqqs_pkg::NUMBER_W-1:0]   next_number;
  pqqs_pkg::result_t               res;

  logic [CW-1:0]                   addr_idx;
  logic [SW-1:0]                   addr_sum;
  logic [AW-1:0]                   head_inc;
  logic [CW-1:0]                   idx_inc;
  logic [CW-1:0]                   idx_dec;
  logic                            in_take;

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && (state == S_IDLE);
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign head_inc = (head == LAST_SLOT) ? '0 : head + AW'(1);

  // logical queue position for this cycle's memory access
  always_comb begin
    case (state)
      S_SCAN_RD:   addr_idx = idx;
      S_SHIFT_RD:  addr_idx = idx_dec;
      S_SHIFT_WR:  addr_idx = idx;
      S_WRITE:     addr_idx = pos;
      S_SERVE_RD:  addr_idx = '0;
      S_SERVE_CHK: addr_idx = occ;
      default:     addr_idx = '0;
    endcase
  end

  // ring position: head + index, folded once
  always_comb begin
    addr_sum = SW'(head) + SW'(addr_idx);
    if (addr_sum >= DEPTH_S) begin
      addr_sum = addr_sum - DEPTH_S;
    end
  end
  assign mem_addr = addr_sum[AW-1:0];

  // memory strobes and write data
  always_comb begin
    mem_rd_en   = (state == S_SCAN_RD) || (state == S_SHIFT_RD) || (state == S_SERVE_RD);
    mem_wr_en   = 1'b0;
    mem_wr_data = mem_rd_data;
    case (state)
      S_SHIFT_WR: begin
        mem_wr_en = 1'b1;
      end
      S_WRITE: begin
        mem_wr_en          = 1'b1;
        mem_wr_data.work   = req_work;
        mem_wr_data.urg    = req_urg;
        mem_wr_data.letter = tk_letter;
        mem_wr_data.number = tk_number;
      end
      S_SERVE_CHK: begin
        mem_wr_en        = alu_res.gt;
        mem_wr_data.work = alu_res.diff;
      end
      default: begin
        mem_wr_en = 1'b0;
      end
    endcase
  end

  // shared unit operands: urgency compare in the scan, work vs quantum on serve
  always_comb begin
    if (state == S_SERVE_CHK) begin
      alu_a = mem_rd_data.work;
      alu_b = quantum;
    end else begin
      alu_a = pqqs_pkg::WORK_W'(mem_rd_data.urg);
      alu_b = pqqs_pkg::WORK_W'(req_urg);
    end
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= pqqs_pkg::QUANTUM_RESET;
    end else if (cfg_write) begin
      quantum <= cfg_data;
    end
  end

  // main sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      head        <= '0;
      occ         <= '0;
      next_letter <= pqqs_pkg::LETTER_FIRST;
      next_number <= pqqs_pkg::NUMBER_FIRST;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_take) begin
            req_work <= work_units;
            req_urg  <= urgency;
            idx      <= '0;
            pos      <= '0;
            if (kind == pqqs_pkg::KIND_ENQUEUE) begin
              if (occ == DEPTH_C) begin
                res.status <= pqqs_pkg::ST_FULL;
                res.urg    <= urgency;
                res.letter <= '0;
                res.number <= '0;
                res.work   <= '0;
                res.count  <= pqqs_pkg::COUNT_W'(occ);
                state      <= S_DONE;
              end else begin
                // take the ticket and advance the counters
                tk_letter <= next_letter;
                tk_number <= next_number;
                if (next_number == pqqs_pkg::NUMBER_LAST) begin
                  next_number <= pqqs_pkg::NUMBER_FIRST;
                  next_letter <= (next_letter == pqqs_pkg::LETTER_LAST) ?
                                 pqqs_pkg::LETTER_FIRST : next_letter + pqqs_pkg::LETTER_W'(1);
                end else begin
                  next_number <= next_number + pqqs_pkg::NUMBER_W'(1);
                end
                state <= (occ == '0) ? S_WRITE : S_SCAN_RD;
              end
            end else begin
              if (occ == '0) begin
                res.status <= pqqs_pkg::ST_EMPTY;
                res.urg    <= '0;
                res.letter <= '0;
                res.number <= '0;
                res.work   <= '0;
                res.count  <= '0;
                state      <= S_DONE;
              end else begin
                state <= S_SERVE_RD;
              end
            end
          end
        end

        S_SCAN_RD: begin
          state <= S_SCAN_CHK;
        end

        // stop at the first entry with a greater urgency value
        S_SCAN_CHK: begin
          if (alu_res.gt) begin
            pos   <= idx;
            idx   <= occ;
            state <= S_SHIFT_RD;
          end else if (idx_inc == occ) begin
            pos   <= occ;
            state <= S_WRITE;
          end else begin
            idx   <= idx_inc;
            state <= S_SCAN_RD;
          end
        end

        S_SHIFT_RD: begin
          state <= S_SHIFT_WR;
        end

        // move entry idx-1 up to idx, walking from the tail down
        S_SHIFT_WR: begin
          idx <= idx_dec;
          if (idx_dec == pos) begin
            state <= S_WRITE;
          end else begin
            state <= S_SHIFT_RD;
          end
        end

        S_WRITE: begin
          occ        <= occ + CW'(1);
          res.status <= pqqs_pkg::ST_ADDED;
          res.urg    <= req_urg;
          res.letter <= tk_letter;
          res.number <= tk_number;
          res.work   <= req_work;
          res.count  <= pqqs_pkg::COUNT_W'(occ + CW'(1));
          state      <= S_DONE;
        end

        S_SERVE_RD: begin
          state <= S_SERVE_CHK;
        end

        // head leaves; requeued copy lands at the new tail
        S_SERVE_CHK: begin
          head       <= head_inc;
          res.urg    <= mem_rd_data.urg;
          res.letter <= mem_rd_data.letter;
          res.number <= mem_rd_data.number;
          if (alu_res.gt) begin
            res.status <= pqqs_pkg::ST_REQUEUED;
            res.work   <= alu_res.diff;
            res.count  <= pqqs_pkg::COUNT_W'(occ);
          end else begin
            occ        <= occ - CW'(1);
            res.status <= pqqs_pkg::ST_DONE;
            res.work   <= '0;
            res.count  <= pqqs_pkg::COUNT_W'(occ - CW'(1));
          end
          state <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
      out_res   <= res;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: hdl/priority_queue_quantum_server_core.sv
// Top level of the priority queue quantum server.
//
// Request channel (in_valid / in_stall): kind 0 enqueues a request with
// work_units and urgency; kind 1 serves the head request. A request is
// taken when in_valid is high and in_stall is low. One request is worked
// at a time; in_stall stays high from acceptance until its result has
// moved into the output register.
// Result channel (out_valid / out_stall): one result per request, held
// stable while out_stall is high. The next request may be accepted while
// a result still waits in the output register.
// Steps: full or empty cases go straight to the result; serve reads the
// head and checks its work; enqueue reads and checks entries, moves the
// later ones up with a read and a write each, then writes the new entry;
// scanned plus shifted entries are at most QUEUE_DEPTH. in_stall drops at
// the edge out_valid rises; the next request can be taken in the cycle
// after. A stalled receiver holds the finished result and keeps in_stall
// up. Memory ports share one address (at most one read or write a cycle).
// Service quantum is written through cfg_write / cfg_data; the user must write it only while idle (not enforced).
// Reset (rst, synchronous) empties the queue, restarts tickets at A1 and
// sets the quantum to 3; entry memory needs no clearing.
module priority_queue_quantum_server_core #(
  parameter int unsigned QUEUE_DEPTH = pqqs_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pqqs_pkg::WORK_W-1:0]        cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               kind,
  input  logic [pqqs_pkg::WORK_W-1:0]        work_units,
  input  logic [pqqs_pkg::URG_W-1:0]         urgency,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [pqqs_pkg::STATUS_W-1:0]      status,
  output logic [pqqs_pkg::URG_W-1:0]         ticket_urgency,
  output logic [pqqs_pkg::LETTER_W-1:0]      ticket_letter,
  output logic [pqqs_pkg::NUMBER_W-1:0]      ticket_number,
  output logic [pqqs_pkg::WORK_W-1:0]        remaining_work,
  output logic [pqqs_pkg::COUNT_W-1:0]       entry_count
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic                         mem_wr_en;
  logic                         mem_rd_en;
  logic [AW-1:0]                mem_addr;
  pqqs_pkg::entry_t             mem_wr_data;
  pqqs_pkg::entry_t             mem_rd_data;
  logic [pqqs_pkg::WORK_W-1:0]  alu_a;
  logic [pqqs_pkg::WORK_W-1:0]  alu_b;
  pqqs_pkg::alu_res_t           alu_res;
  pqqs_pkg::result_t            out_res;

  // sequencer
  pqqs_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW),
    .CW          (CW)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_write),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .work_units  (work_units),
    .urgency     (urgency),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (out_res),
    .mem_wr_en   (mem_wr_en),
    .mem_rd_en   (mem_rd_en),
    .mem_addr    (mem_addr),
    .mem_wr_data (mem_wr_data),
    .mem_rd_data (mem_rd_data),
    .alu_a       (alu_a),
    .alu_b       (alu_b),
    .alu_res     (alu_res)
  );

  // entry memory
  pqqs_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .AW          (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_addr),
    .wr_data (mem_wr_data),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_addr),
    .rd_data (mem_rd_data)
  );

  // shared compare / subtract
  pqqs_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .res (alu_res)
  );

  // result fields
  assign status         = out_res.status;
  assign ticket_urgency = out_res.urg;
  assign ticket_letter  = out_res.letter;
  assign ticket_number  = out_res.number;
  assign remaining_work = out_res.work;
  assign entry_count    = out_res.count;

endmodule

// File: hdl/pqqs_checker.sv
// Port-level checks for the priority queue quantum server, bound to the top.
module pqqs_checker #(
  parameter int unsigned QUEUE_DEPTH = pqqs_pkg::DEPTH_DEFAULT
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [pqqs_pkg::STATUS_W-1:0]  status,
  input logic [pqqs_pkg::LETTER_W-1:0]  ticket_letter,
  input logic [pqqs_pkg::NUMBER_W-1:0]  ticket_number,
  input logic [pqqs_pkg::WORK_W-1:0]    remaining_work,
  input logic [pqqs_pkg::COUNT_W-1:0]   entry_count
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(ticket_number))
    else $error("result changed while stalled");

  // empty serve reports an empty queue with zero fields
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pqqs_pkg::ST_EMPTY) |->
      (entry_count == '0) && (ticket_number == '0) && (remaining_work == '0))
    else $error("empty result carries data");

  // an added or served request always carries a real ticket
  a_ticket_real: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == pqqs_pkg::ST_ADDED) || (status == pqqs_pkg::ST_DONE) ||
                  (status == pqqs_pkg::ST_REQUEUED)) |->
      (ticket_number != '0) && (ticket_letter <= pqqs_pkg::LETTER_LAST))
    else $error("missing ticket");

  // a requeued request still has work and stays in the queue
  a_requeue: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == pqqs_pkg::ST_REQUEUED) |->
      (remaining_work != '0) && (entry_count != '0))
    else $error("requeue with no work or empty queue");

  // after reset nothing is offered
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("busy after reset");

endmodule

bind priority_queue_quantum_server_core pqqs_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pqqs_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .status         (status),
  .ticket_letter  (ticket_letter),
  .ticket_number  (ticket_number),
  .remaining_work (remaining_work),
  .entry_count    (entry_count)
);
